>>> sv/twsf_pkg.sv
package twsf_pkg;

    // default sizes of the subscription table
    localparam int NUM_SLOTS_DEF   = 16;
    localparam int MAX_PATTERN_DEF = 32;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // most match entries given for one message
    localparam int RESULT_CAP = 16;

    // matcher position width: a position may run two past a 6-bit length
    localparam int POS_W = 7;

    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_DOT  = 8'h2E;

    localparam logic [1:0] KIND_STATUS  = 2'd0;
    localparam logic [1:0] KIND_MATCH   = 2'd1;
    localparam logic [1:0] KIND_NOMATCH = 2'd2;

    localparam logic STAT_OK  = 1'b0;
    localparam logic STAT_ERR = 1'b1;

    typedef enum logic [2:0] {
        OPC_LOAD     = 3'd0,
        OPC_COMMIT   = 3'd1,
        OPC_REM_SLOT = 3'd2,
        OPC_REM_SUB  = 3'd3,
        OPC_MSG      = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        MODE_LIT  = 2'd0,
        MODE_WILD = 2'd1,
        MODE_HIT  = 2'd2,
        MODE_MISS = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SLOT,
        ST_ADV,
        ST_OPEN_A,
        ST_OPEN_B,
        ST_LIT_A,
        ST_LIT_B,
        ST_DONE_SLOT,
        ST_FLUSH
    } state_t;

    // classified command handed from front to back
    typedef struct packed {
        opcode_t     op;
        logic        slot_ok;
        logic [3:0]  slot;
        logic [5:0]  position;
        logic [7:0]  data;
        logic [15:0] sub;
        logic        last;
    } cmd_t;

endpackage

>>> sv/topic_wildcard_subscription_filter_unit.sv
// Dotted topic wildcard subscription filter.
// Input stream s_axis carries table commands and message bytes: load a
// pattern byte, commit a slot, remove a slot, remove a subscriber, or one
// message byte, with tlast on the final byte of a message.
// Output stream m_axis carries results: a status for each table command,
// one match entry per matching slot in slot order (at most 16), or one
// no-match result; tlast marks the last result of a transaction.
// A front stage classifies transactions into a 4-entry command queue, so
// input is taken while the engine works. The engine walks the slots one by
// one against the pattern memory (one read port, registered read): loads and
// table commands are done in the idle state, a message byte walks every slot,
// and the last byte of a message adds the final result.
// Reset empties all slots and the queue and starts a new message; pattern
// bytes are undefined until loaded. A stalled receiver holds the output
// register; the engine waits, and the queue backs up to s_axis_tready.
module topic_wildcard_subscription_filter_unit #(
    parameter int NUM_SLOTS   = twsf_pkg::NUM_SLOTS_DEF,
    parameter int MAX_PATTERN = twsf_pkg::MAX_PATTERN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[2:0], slot[6:3], position[12:7], data_byte[20:13],
    // subscriber_id[36:21], zero[39:37]
    input  logic [39:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[0], match_subscriber[16:1], zero[23:17]
    output logic [23:0] m_axis_tdata,
    // kind[1:0]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    import twsf_pkg::*;

    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    twsf_front #(
        .NUM_SLOTS   (NUM_SLOTS),
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_pop         (q_pop)
    );

    twsf_back #(
        .NUM_SLOTS   (NUM_SLOTS),
        .MAX_PATTERN (MAX_PATTERN)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // the engine pops only a queued command
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("queue popped while empty");

    // a no-match result always closes its message
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_NOMATCH)) |-> m_axis_tlast)
        else $error("no-match result without tlast");

    // a status result is single and carries no subscriber
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_STATUS))
        |-> (m_axis_tlast && (m_axis_tdata[16:1] == 16'h0000)))
        else $error("malformed status result");

endmodule

>>> sv/twsf_ram.sv
module twsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

>>> sv/twsf_front.sv
module twsf_front #(
    parameter int NUM_SLOTS   = twsf_pkg::NUM_SLOTS_DEF,
    parameter int MAX_PATTERN = twsf_pkg::MAX_PATTERN_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    // opcode[2:0], slot[6:3], position[12:7], data_byte[20:13],
    // subscriber_id[36:21], zero[39:37]
    input  logic [39:0]    s_axis_tdata,
    input  logic           s_axis_tlast,
    output logic           q_valid,
    output twsf_pkg::cmd_t q_cmd,
    input  logic           q_pop
);
    import twsf_pkg::*;

    localparam int QW = $clog2(QUEUE_DEPTH);

    logic [2:0]  op_field;
    logic [3:0]  slot_field;
    logic [5:0]  pos_field;
    logic        slot_ok;
    logic        keep;
    logic        push;
    cmd_t        cmd;

    cmd_t        queue_reg [QUEUE_DEPTH];
    logic [QW-1:0] wr_ptr_reg;
    logic [QW-1:0] wr_ptr_next;
    logic [QW-1:0] rd_ptr_reg;
    logic [QW-1:0] rd_ptr_next;
    logic [QW:0]   count_reg;
    logic [QW:0]   count_next;

    assign op_field   = s_axis_tdata[2:0];
    assign slot_field = s_axis_tdata[6:3];
    assign pos_field  = s_axis_tdata[12:7];
    assign slot_ok    = 32'(slot_field) < 32'(NUM_SLOTS);

    // classify the transaction: drop unknown opcodes and out-of-range loads
    always_comb
    begin
        cmd.op       = opcode_t'(op_field);
        cmd.slot_ok  = slot_ok;
        cmd.slot     = slot_field;
        cmd.position = pos_field;
        cmd.data     = s_axis_tdata[20:13];
        cmd.sub      = s_axis_tdata[36:21];
        cmd.last     = s_axis_tlast;
        keep         = 1'b0;
        case (op_field)
            OPC_LOAD:
            begin
                keep = slot_ok && (32'(pos_field) < 32'(MAX_PATTERN));
            end
            OPC_COMMIT:
            begin
                keep = 1'b1;
                // saturate the committed length
                if (32'(pos_field) > 32'(MAX_PATTERN))
                begin
                    cmd.position = 6'(MAX_PATTERN);
                end
            end
            OPC_REM_SLOT, OPC_REM_SUB, OPC_MSG:
            begin
                keep = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_axis_tready = (count_reg != (QW+1)'(QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready && keep;
    assign q_valid       = (count_reg != '0);
    assign q_cmd         = queue_reg[rd_ptr_reg];

    // advance queue pointers
    always_comb
    begin
        wr_ptr_next = push  ? wr_ptr_reg + QW'(1) : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + QW'(1) : rd_ptr_reg;
        count_next  = count_reg + (QW+1)'(push) - (QW+1)'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // hold queued commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

>>> sv/twsf_back.sv
module twsf_back #(
    parameter int NUM_SLOTS   = twsf_pkg::NUM_SLOTS_DEF,
    parameter int MAX_PATTERN = twsf_pkg::MAX_PATTERN_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  twsf_pkg::cmd_t q_cmd,
    output logic           q_pop,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // status[0], match_subscriber[16:1], zero[23:17]
    output logic [23:0]    m_axis_tdata,
    // kind[1:0]
    output logic [1:0]     m_axis_tuser,
    output logic           m_axis_tlast
);
    import twsf_pkg::*;

    localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int DEPTH = NUM_SLOTS * MAX_PATTERN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = $clog2(RESULT_CAP + 1);

    // control state
    state_t          state_reg;
    state_t          state_next;
    logic [SW-1:0]   slot_cnt_reg;
    logic [SW-1:0]   slot_cnt_next;
    mode_t           wmode_reg;
    mode_t           wmode_next;
    logic [POS_W-1:0] wpos_reg;
    logic [POS_W-1:0] wpos_next;
    logic [POS_W-1:0] rd_pos_reg;
    logic [POS_W-1:0] rd_pos_next;
    logic            open_ctx_reg;
    logic            open_ctx_next;
    logic [7:0]      d_reg;
    logic [7:0]      d_next;
    logic            last_reg;
    logic            last_next;
    logic            msg_start_reg;
    logic            msg_start_next;
    logic [NW-1:0]   n_reg;
    logic [NW-1:0]   n_next;
    logic            pend_valid_reg;
    logic            pend_valid_next;
    logic [15:0]     pend_sub_reg;
    logic [15:0]     pend_sub_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic [1:0]      out_kind_reg;
    logic [1:0]      out_kind_next;
    logic            out_status_reg;
    logic            out_status_next;
    logic [15:0]     out_sub_reg;
    logic [15:0]     out_sub_next;
    logic            out_last_reg;
    logic            out_last_next;

    // slot table
    logic            valid_reg [NUM_SLOTS];
    logic [15:0]     sub_reg   [NUM_SLOTS];
    logic [5:0]      len_reg   [NUM_SLOTS];
    mode_t           mode_reg  [NUM_SLOTS];
    logic [POS_W-1:0] pos_reg  [NUM_SLOTS];

    // shared decode
    logic [SW-1:0]   cmd_idx;
    logic            out_free;
    logic            cur_valid;
    logic            slot_last;
    logic            hit_take;
    logic            done_stall;
    logic            status_op;
    logic            idle_go;
    logic [7:0]      c_byte;
    state_t          open_exit;
    logic [POS_W-1:0] rd_p;

    // table write enables
    logic            commit_we;
    logic            rem_we;
    logic            remsub_we;
    logic            slot_we;

    // pattern memory
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [AW-1:0]   ram_raddr;
    logic [7:0]      ram_rdata;

    twsf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_pattern (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (q_cmd.data),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_waddr = AW'(q_cmd.slot) * AW'(MAX_PATTERN) + AW'(q_cmd.position);
    assign ram_raddr = AW'(slot_cnt_reg) * AW'(MAX_PATTERN) + AW'(rd_p);

    // decode conditions used by both state and datapath logic
    always_comb
    begin
        cmd_idx    = SW'(q_cmd.slot);
        out_free   = !out_valid_reg || m_axis_tready;
        cur_valid  = valid_reg[slot_cnt_reg];
        slot_last  = (slot_cnt_reg == SW'(NUM_SLOTS - 1));
        // hits are reported only on the last byte of a message
        hit_take   = last_reg && cur_valid && (wmode_reg == MODE_HIT)
                     && (n_reg < NW'(RESULT_CAP));
        done_stall = hit_take && pend_valid_reg && !out_free;
        status_op  = (q_cmd.op == OPC_COMMIT) || (q_cmd.op == OPC_REM_SLOT)
                     || (q_cmd.op == OPC_REM_SUB);
        idle_go    = q_valid && (!status_op || out_free);
        // pattern bytes past the committed length read as zero
        c_byte     = (rd_pos_reg < POS_W'(len_reg[slot_cnt_reg])) ? ram_rdata : 8'h00;
        open_exit  = open_ctx_reg ? ST_ADV : ST_DONE_SLOT;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && (q_cmd.op == OPC_MSG))
                begin
                    state_next = ST_SLOT;
                end
            end
            ST_SLOT:
            begin
                if (!cur_valid)
                begin
                    state_next = ST_DONE_SLOT;
                end
                else if (msg_start_reg)
                begin
                    state_next = ST_OPEN_A;
                end
                else
                begin
                    state_next = ST_ADV;
                end
            end
            ST_ADV:
            begin
                if (wmode_reg == MODE_LIT)
                begin
                    state_next = ST_LIT_A;
                end
                else if ((wmode_reg == MODE_WILD) && (d_reg == CH_DOT))
                begin
                    state_next = ST_OPEN_A;
                end
                else
                begin
                    state_next = ST_DONE_SLOT;
                end
            end
            ST_OPEN_A:
            begin
                state_next = (c_byte == CH_STAR) ? ST_OPEN_B : open_exit;
            end
            ST_OPEN_B:
            begin
                state_next = open_exit;
            end
            ST_LIT_A:
            begin
                if (c_byte == 8'h00)
                begin
                    state_next = ST_DONE_SLOT;
                end
                else if (c_byte == CH_DOT)
                begin
                    state_next = (d_reg == CH_DOT) ? ST_OPEN_A : ST_DONE_SLOT;
                end
                else if (c_byte != d_reg)
                begin
                    state_next = ST_DONE_SLOT;
                end
                else
                begin
                    state_next = ST_LIT_B;
                end
            end
            ST_LIT_B:
            begin
                state_next = ST_DONE_SLOT;
            end
            ST_DONE_SLOT:
            begin
                if (done_stall)
                begin
                    state_next = ST_DONE_SLOT;
                end
                else if (slot_last)
                begin
                    state_next = last_reg ? ST_FLUSH : ST_IDLE;
                end
                else
                begin
                    state_next = ST_SLOT;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        q_pop           = 1'b0;
        ram_we          = 1'b0;
        commit_we       = 1'b0;
        rem_we          = 1'b0;
        remsub_we       = 1'b0;
        slot_we         = 1'b0;
        rd_p            = wpos_reg;
        slot_cnt_next   = slot_cnt_reg;
        wmode_next      = wmode_reg;
        wpos_next       = wpos_reg;
        open_ctx_next   = open_ctx_reg;
        d_next          = d_reg;
        last_next       = last_reg;
        msg_start_next  = msg_start_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_sub_next   = pend_sub_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_kind_next   = out_kind_reg;
        out_status_next = out_status_reg;
        out_sub_next    = out_sub_reg;
        out_last_next   = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                q_pop = idle_go;
                if (idle_go)
                begin
                    case (q_cmd.op)
                        OPC_LOAD:
                        begin
                            ram_we = 1'b1;
                        end
                        OPC_COMMIT, OPC_REM_SLOT, OPC_REM_SUB:
                        begin
                            out_valid_next  = 1'b1;
                            out_kind_next   = KIND_STATUS;
                            out_status_next = STAT_OK;
                            out_sub_next    = '0;
                            out_last_next   = 1'b1;
                            if (q_cmd.op == OPC_REM_SUB)
                            begin
                                remsub_we = 1'b1;
                            end
                            else if (!q_cmd.slot_ok)
                            begin
                                out_status_next = STAT_ERR;
                            end
                            else if (q_cmd.op == OPC_COMMIT)
                            begin
                                commit_we = 1'b1;
                            end
                            else if (!valid_reg[cmd_idx])
                            begin
                                out_status_next = STAT_ERR;
                            end
                            else
                            begin
                                rem_we = 1'b1;
                            end
                        end
                        OPC_MSG:
                        begin
                            d_next          = q_cmd.data;
                            last_next       = q_cmd.last;
                            slot_cnt_next   = '0;
                            n_next          = '0;
                            pend_valid_next = 1'b0;
                        end
                        default:
                        begin
                            q_pop = idle_go;
                        end
                    endcase
                end
            end
            ST_SLOT:
            begin
                wmode_next = mode_reg[slot_cnt_reg];
                wpos_next  = pos_reg[slot_cnt_reg];
                if (cur_valid && msg_start_reg)
                begin
                    rd_p          = '0;
                    open_ctx_next = 1'b1;
                end
            end
            ST_ADV:
            begin
                if (wmode_reg == MODE_WILD)
                begin
                    if (d_reg == CH_DOT)
                    begin
                        rd_p          = wpos_reg + POS_W'(1);
                        open_ctx_next = 1'b0;
                    end
                    else if (d_reg == 8'h00)
                    begin
                        wmode_next = MODE_MISS;
                    end
                end
            end
            ST_OPEN_A:
            begin
                wpos_next = rd_pos_reg;
                if (c_byte == 8'h00)
                begin
                    wmode_next = MODE_HIT;
                end
                else if (c_byte == CH_STAR)
                begin
                    rd_p = rd_pos_reg + POS_W'(1);
                end
                else
                begin
                    wmode_next = MODE_LIT;
                end
            end
            ST_OPEN_B:
            begin
                wpos_next = rd_pos_reg;
                if (c_byte == 8'h00)
                begin
                    wmode_next = MODE_HIT;
                end
                else if (c_byte == CH_DOT)
                begin
                    wmode_next = MODE_WILD;
                end
                else
                begin
                    wmode_next = MODE_MISS;
                end
            end
            ST_LIT_A:
            begin
                if (c_byte == 8'h00)
                begin
                    wmode_next = MODE_HIT;
                end
                else if (c_byte == CH_DOT)
                begin
                    if (d_reg == CH_DOT)
                    begin
                        rd_p          = wpos_reg + POS_W'(1);
                        open_ctx_next = 1'b0;
                    end
                    else
                    begin
                        wmode_next = MODE_MISS;
                    end
                end
                else if (c_byte != d_reg)
                begin
                    wmode_next = MODE_MISS;
                end
                else
                begin
                    wpos_next = wpos_reg + POS_W'(1);
                    rd_p      = wpos_reg + POS_W'(1);
                end
            end
            ST_LIT_B:
            begin
                if (c_byte == 8'h00)
                begin
                    wmode_next = MODE_HIT;
                end
            end
            ST_DONE_SLOT:
            begin
                if (!done_stall)
                begin
                    slot_we = 1'b1;
                    // emit the previous hit, keep this one pending
                    if (hit_take)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_kind_next   = KIND_MATCH;
                            out_status_next = STAT_OK;
                            out_sub_next    = pend_sub_reg;
                            out_last_next   = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_sub_next   = sub_reg[slot_cnt_reg];
                        n_next          = n_reg + NW'(1);
                    end
                    if (slot_last)
                    begin
                        msg_start_next = last_reg;
                    end
                    else
                    begin
                        slot_cnt_next = slot_cnt_reg + SW'(1);
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_OK;
                    out_last_next   = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_kind_next = KIND_MATCH;
                        out_sub_next  = pend_sub_reg;
                    end
                    else
                    begin
                        out_kind_next = KIND_NOMATCH;
                        out_sub_next  = '0;
                    end
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
        rd_pos_next = rd_p;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            msg_start_reg  <= 1'b1;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            open_ctx_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            msg_start_reg  <= msg_start_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
            open_ctx_reg   <= open_ctx_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        slot_cnt_reg   <= slot_cnt_next;
        wmode_reg      <= wmode_next;
        wpos_reg       <= wpos_next;
        rd_pos_reg     <= rd_pos_next;
        d_reg          <= d_next;
        last_reg       <= last_next;
        n_reg          <= n_next;
        pend_sub_reg   <= pend_sub_next;
        out_kind_reg   <= out_kind_next;
        out_status_reg <= out_status_next;
        out_sub_reg    <= out_sub_next;
        out_last_reg   <= out_last_next;
    end

    // slot valid bits and matcher state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_SLOTS; s++)
            begin
                valid_reg[s] <= 1'b0;
                mode_reg[s]  <= MODE_LIT;
                pos_reg[s]   <= '0;
            end
        end
        else
        begin
            if (commit_we)
            begin
                valid_reg[cmd_idx] <= 1'b1;
                mode_reg[cmd_idx]  <= MODE_MISS;
                pos_reg[cmd_idx]   <= '0;
            end
            if (rem_we)
            begin
                valid_reg[cmd_idx] <= 1'b0;
            end
            if (remsub_we)
            begin
                for (int s = 0; s < NUM_SLOTS; s++)
                begin
                    if (sub_reg[s] == q_cmd.sub)
                    begin
                        valid_reg[s] <= 1'b0;
                    end
                end
            end
            if (slot_we)
            begin
                mode_reg[slot_cnt_reg] <= wmode_reg;
                pos_reg[slot_cnt_reg]  <= wpos_reg;
            end
        end
    end

    // committed length and subscriber
    always_ff @(posedge clk)
    begin
        if (commit_we)
        begin
            len_reg[cmd_idx] <= q_cmd.position;
            sub_reg[cmd_idx] <= q_cmd.sub;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_sub_reg, out_status_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

>>> tb/tb_topic_wildcard_subscription_filter_unit.sv
`timescale 1ns / 1ps

module tb_topic_wildcard_subscription_filter_unit;
    import twsf_pkg::*;

    localparam int NSLOT       = 16;
    localparam int PLEN_MAX    = 32;
    localparam int MATCH_CAP   = 16;
    localparam int OPC_UNUSED_LO = 5;
    localparam int OPC_UNUSED_HI = 7;
    localparam int TARGET_ITEMS  = 420;

    typedef struct packed {
        logic [1:0]  kind;
        logic        status;
        logic [15:0] sub;
        logic        fin;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    topic_wildcard_subscription_filter_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // shadow of the subscription table and matchers
    logic [7:0]  pat_mem [NSLOT][PLEN_MAX];
    bit          pat_written [NSLOT][PLEN_MAX];
    int          pat_len [NSLOT];
    bit          slot_used [NSLOT];
    logic [15:0] slot_sub [NSLOT];
    int          mpos [NSLOT];
    mode_t       mmode [NSLOT];
    bit          msg_start;

    result_t     expected_results[$];
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          items_sent;
    int          results_seen;
    int          match_entries_seen;
    int          error_count;
    logic [15:0] sub_pool[$];

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    // ---------------- predictor ----------------

    function automatic logic [7:0] pattern_at(int s, int p);
        if (p >= pat_len[s] || p >= PLEN_MAX)
            return 8'h00;
        return pat_mem[s][p];
    endfunction

    function automatic void open_element(int s, int p);
        logic [7:0] c;
        c = pattern_at(s, p);
        if (c == 8'h00)
            mmode[s] = MODE_HIT;
        else if (c == CH_STAR)
        begin
            p++;
            c = pattern_at(s, p);
            if (c == 8'h00)
                mmode[s] = MODE_HIT;
            else if (c == CH_DOT)
                mmode[s] = MODE_WILD;
            else
                mmode[s] = MODE_MISS;
        end
        else
            mmode[s] = MODE_LIT;
        mpos[s] = p;
    endfunction

    function automatic void step_matcher(int s, logic [7:0] d);
        logic [7:0] c;
        if (mmode[s] == MODE_LIT)
        begin
            c = pattern_at(s, mpos[s]);
            if (c == 8'h00)
                mmode[s] = MODE_HIT;
            else if (c == CH_DOT)
            begin
                if (d == CH_DOT)
                    open_element(s, mpos[s] + 1);
                else
                    mmode[s] = MODE_MISS;
            end
            else if (c != d)
                mmode[s] = MODE_MISS;
            else
            begin
                mpos[s]++;
                if (pattern_at(s, mpos[s]) == 8'h00)
                    mmode[s] = MODE_HIT;
            end
        end
        else if (mmode[s] == MODE_WILD)
        begin
            if (d == CH_DOT)
                open_element(s, mpos[s] + 1);
            else if (d == 8'h00)
                mmode[s] = MODE_MISS;
        end
    endfunction

    // append one expected result at the tail of the queue
    function automatic void add_expected(logic [1:0] kind, logic st,
                                         logic [15:0] sub, logic fin);
        result_t r;
        r.kind   = kind;
        r.status = st;
        r.sub    = sub;
        r.fin    = fin;
        expected_results = {expected_results, r};
    endfunction

    function automatic void push_status(logic st);
        add_expected(KIND_STATUS, st, 16'h0, 1'b1);
    endfunction

    // apply one accepted transaction and queue the results it causes
    function automatic void predict_filter(logic [2:0] op, logic [3:0] slot,
                                           logic [5:0] posn, logic [7:0] d,
                                           logic [15:0] sub, logic last);
        int n;
        n = 0;
        case (op)
            OPC_LOAD:
            begin
                if (posn < PLEN_MAX)
                begin
                    pat_mem[slot][posn] = d;
                    pat_written[slot][posn] = 1'b1;
                end
            end
            OPC_COMMIT:
            begin
                pat_len[slot]   = (posn > PLEN_MAX) ? PLEN_MAX : posn;
                slot_sub[slot]  = sub;
                slot_used[slot] = 1'b1;
                mpos[slot]      = 0;
                mmode[slot]     = MODE_MISS;
                push_status(STAT_OK);
            end
            OPC_REM_SLOT:
            begin
                push_status(slot_used[slot] ? STAT_OK : STAT_ERR);
                slot_used[slot] = 1'b0;
            end
            OPC_REM_SUB:
            begin
                for (int s = 0; s < NSLOT; s++)
                    if (slot_used[s] && slot_sub[s] == sub)
                        slot_used[s] = 1'b0;
                push_status(STAT_OK);
            end
            OPC_MSG:
            begin
                if (msg_start)
                    for (int s = 0; s < NSLOT; s++)
                        open_element(s, 0);
                for (int s = 0; s < NSLOT; s++)
                    if (slot_used[s])
                        step_matcher(s, d);
                msg_start = last;
                if (last)
                begin
                    for (int s = 0; s < NSLOT && n < MATCH_CAP; s++)
                        if (slot_used[s] && mmode[s] == MODE_HIT)
                        begin
                            add_expected(KIND_MATCH, STAT_OK, slot_sub[s], 1'b0);
                            n++;
                        end
                    if (n == 0)
                        add_expected(KIND_NOMATCH, STAT_OK, 16'h0, 1'b1);
                    else
                        expected_results[$].fin = 1'b1;
                end
            end
            default: ;
        endcase
    endfunction

    // ---------------- driver ----------------

    // send one transaction; entered and left at a falling edge
    task automatic send_item(logic [2:0] op, logic [3:0] slot, logic [5:0] posn,
                             logic [7:0] d, logic [15:0] sub, logic last);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < tx_idle_pct)
                @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, sub, d, posn, slot, op};
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_filter(op, slot, posn, d, sub, last);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic commit_slot(int slot, int len, logic [15:0] sub);
        int top;
        top = (len > PLEN_MAX) ? PLEN_MAX : len;
        // fill any byte the committed length would reach but was never loaded
        for (int p = 0; p < top; p++)
            if (!pat_written[slot][p])
                send_item(OPC_LOAD, slot, p, "a", $urandom, 1'b0);
        send_item(OPC_COMMIT, slot, len, $urandom, sub, $urandom_range(1));
        sub_pool = {sub_pool, sub};
    endtask

    task automatic program_slot(int slot, string pat, logic [15:0] sub);
        for (int p = 0; p < pat.len(); p++)
            send_item(OPC_LOAD, slot, p, pat[p], $urandom, $urandom_range(1));
        commit_slot(slot, pat.len(), sub);
    endtask

    task automatic send_message(string msg);
        for (int i = 0; i < msg.len(); i++)
            send_item(OPC_MSG, $urandom, $urandom, msg[i], $urandom,
                      i == msg.len() - 1);
    endtask

    function automatic string random_text(string alphabet, int len);
        string t;
        int k;
        t = "";
        for (int i = 0; i < len; i++)
        begin
            k = $urandom_range(alphabet.len() - 1);
            t = {t, alphabet.substr(k, k)};
        end
        return t;
    endfunction

    // ---------------- result checker ----------------

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    always @(negedge clk)
        if (rst_n)
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                want = expected_results.pop_front();
                if (m_axis_tuser != want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d",
                                              m_axis_tuser, want.kind));
                if (m_axis_tdata[0] != want.status)
                    report_mismatch($sformatf("status %0b, want %0b",
                                              m_axis_tdata[0], want.status));
                if (m_axis_tdata[16:1] != want.sub)
                    report_mismatch($sformatf("subscriber %h, want %h",
                                              m_axis_tdata[16:1], want.sub));
                if (m_axis_tdata[23:17] != 7'h0)
                    report_mismatch("nonzero pad bits in result");
                if (m_axis_tlast != want.fin)
                    report_mismatch($sformatf("last %0b, want %0b",
                                              m_axis_tlast, want.fin));
                if (want.kind == KIND_MATCH)
                    match_entries_seen++;
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_table_ops();
        send_item(OPC_REM_SLOT, 4'd0, 6'd0, 8'h00, 16'h0000, 1'b0);
        program_slot(15, "a.b", 16'hFFFF);
        send_item(OPC_REM_SLOT, 4'd15, 6'd63, 8'hFF, 16'hFFFF, 1'b1);
        send_item(OPC_REM_SLOT, 4'd15, 6'd0, 8'h00, 16'h0000, 1'b0);
        program_slot(3, "x", 16'h1234);
        program_slot(4, "y", 16'h1234);
        send_item(OPC_REM_SUB, 4'd0, 6'd0, 8'h00, 16'h1234, 1'b0);
        // ignored: out-of-range load position and unused opcodes
        send_item(OPC_LOAD, 4'd2, 6'd63, 8'hFF, 16'h0, 1'b0);
        send_item(OPC_LOAD, 4'd2, 6'd32, 8'hAA, 16'h0, 1'b1);
        for (int op = OPC_UNUSED_LO; op <= OPC_UNUSED_HI; op++)
            send_item(op, $urandom, $urandom, $urandom, $urandom, $urandom_range(1));
    endtask

    task automatic test_wildcards();
        program_slot(0, "a.*.c", 16'h0001);
        program_slot(1, "*.b", 16'h0002);
        program_slot(2, "a*", 16'h0003);
        program_slot(5, "*", 16'h0005);
        send_message("a.zz.c");
        send_message("q.b.extra");
        // message with a zero byte in the middle
        send_item(OPC_MSG, $urandom, $urandom, "a", $urandom, 1'b0);
        send_item(OPC_MSG, $urandom, $urandom, 8'h00, $urandom, 1'b0);
        send_item(OPC_MSG, $urandom, $urandom, "c", $urandom, 1'b1);
        send_message("ab");
        // saturated length on a fully loaded slot
        commit_slot(6, 40, 16'h0006);
        send_message("a");
        // every slot with an empty pattern: full match list
        for (int s = 0; s < NSLOT; s++)
            commit_slot(s, 0, 16'h8000 | s);
        send_message("z");
    endtask

    task automatic random_table_op();
        int pick;
        int slot;
        pick = $urandom_range(99);
        slot = $urandom_range(NSLOT - 1);
        if (pick < 40)
            program_slot(slot, random_text("ab.**", $urandom_range(6)),
                         ($urandom_range(3) == 0) ? $urandom : $urandom_range(7));
        else if (pick < 55)
            send_item(OPC_REM_SLOT, slot, $urandom, $urandom, $urandom, $urandom);
        else if (pick < 68 && sub_pool.size() > 0)
            send_item(OPC_REM_SUB, $urandom, $urandom, $urandom,
                      sub_pool[$urandom_range(sub_pool.size() - 1)], $urandom);
        else if (pick < 80)
            send_item(OPC_LOAD, slot, $urandom_range(PLEN_MAX - 1),
                      ($urandom_range(1) == 0) ? $urandom : 8'h00, $urandom, $urandom);
        else if (pick < 90)
            send_item(OPC_LOAD, slot, $urandom_range(63, PLEN_MAX), $urandom,
                      $urandom, $urandom);
        else
            send_item($urandom_range(OPC_UNUSED_HI, OPC_UNUSED_LO), $urandom,
                      $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic test_random_traffic(int count);
        int stop_at;
        int len;
        logic [7:0] b;
        string alpha;
        alpha = "ab.c";
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(99) < 55)
            begin
                len = $urandom_range(1, 7);
                for (int i = 0; i < len; i++)
                begin
                    // occasional table change in the middle of a message
                    if (i > 0 && $urandom_range(99) < 6)
                        random_table_op();
                    b = ($urandom_range(9) == 0) ? $urandom : alpha[$urandom_range(3)];
                    if ($urandom_range(19) == 0)
                        b = 8'h00;
                    send_item(OPC_MSG, $urandom, $urandom, b, $urandom, i == len - 1);
                end
            end
            else
                random_table_op();
        end
    endtask

    initial
    begin
        int per_phase;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        items_sent    = 0;
        results_seen  = 0;
        match_entries_seen = 0;
        error_count   = 0;
        msg_start     = 1'b1;
        for (int s = 0; s < NSLOT; s++)
        begin
            slot_used[s] = 1'b0;
            pat_len[s]   = 0;
            mpos[s]      = 0;
            mmode[s]     = MODE_LIT;
            for (int p = 0; p < PLEN_MAX; p++)
                pat_written[s][p] = 1'b0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        tx_idle_pct = 16;
        rx_idle_pct = 79;
        test_table_ops();
        test_wildcards();
        // spread the remaining item budget over the three idle phases
        per_phase = (TARGET_ITEMS - items_sent) / 3;
        if (per_phase < 40)
            per_phase = 40;
        test_random_traffic(per_phase);
        tx_idle_pct = 79;
        rx_idle_pct = 16;
        test_random_traffic(per_phase);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic(per_phase);

        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        $display("sent %0d transactions, checked %0d results (%0d match entries)",
                 items_sent, results_seen, match_entries_seen);
        $display("covered table commands, wildcard and prefix matching, idle phases");
        if (error_count == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
